// ----- design/sorted_timestamp_nearest_lookup_defines.svh -----
`ifndef SORTED_TIMESTAMP_NEAREST_LOOKUP_DEFINES_SVH
`define SORTED_TIMESTAMP_NEAREST_LOOKUP_DEFINES_SVH

// Both macros expect clk and rst_n in the enclosing scope.
`define STL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stl assertion failed");

`define STL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stl assertion failed");

`endif

// ----- design/stl_pkg.sv -----
`timescale 1ns / 1ps

package stl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int OP_W = 3;
    localparam int STAMP_W = 64;
    localparam int SLOT_W = 6;
    localparam int STATUS_W = 2;
    localparam int FRAC_W = 16;
    localparam int POS_W = 6;
    localparam int FILL_W = 7;
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W + 1;
    localparam int DIV_CNT_W = $clog2(FRAC_W);

    localparam int IN_TDATA_W = 80;
    localparam int OUT_TDATA_W = 288;
    localparam int OUT_USED_W = STATUS_W + 1 + 4 * STAMP_W + FRAC_W + POS_W + FILL_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_READ   = 3'd2,
        OP_FIND   = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RA_PTR_M1,
        RA_MID,
        RA_SLOT,
        RA_LO,
        RA_LO_M1
    } raddr_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_INS_CMP,
        S_INS_PUT,
        S_RD_CAP,
        S_BS_CHK,
        S_BS_CMP,
        S_BS_END,
        S_FIND_CMP,
        S_Q_UP,
        S_Q_LO_REQ,
        S_Q_LO,
        S_Q_EVAL,
        S_Q_OFF,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       clr_count;
        logic       set_full;
        logic       set_bad_index;
        logic       set_not_found;
        raddr_sel_t raddr_sel;
        logic       ram_we;
        logic       wr_stamp;
        logic       ptr_dec;
        logic       cnt_inc;
        logic       bs_step;
        logic       cap_lower;
        logic       cap_upper;
        logic       set_pos;
        logic       eval;
        logic       calc_off;
        logic       div_step;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            slot_ok;
        logic            count_zero;
        logic            ptr_zero;
        logic            bs_more;
        logic            greater;
        logic            equal;
        logic            has_lo;
        logic            has_up;
        logic            need_div;
        logic            div_last;
        logic            out_busy;
    } dp_stat_t;

endpackage

// ----- design/stl_ram.sv -----
`timescale 1ns / 1ps

module stl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/stl_ctrl.sv -----
`timescale 1ns / 1ps

module stl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  stl_pkg::dp_stat_t stat,
    output stl_pkg::dp_cmd_t  cmd
);

    import stl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_INSERT: state_next = stat.full ? S_DONE : S_INS_CHK;
                    OP_READ:   state_next = stat.slot_ok ? S_RD_CAP : S_DONE;
                    OP_FIND:   state_next = S_BS_CHK;
                    OP_QUERY:  state_next = stat.count_zero ? S_DONE : S_BS_CHK;
                    default:   state_next = S_DONE;
                endcase
            end
            S_INS_CHK:  state_next = stat.ptr_zero ? S_INS_PUT : S_INS_CMP;
            S_INS_CMP:  state_next = stat.greater ? S_INS_CHK : S_INS_PUT;
            S_INS_PUT:  state_next = S_DONE;
            S_RD_CAP:   state_next = S_DONE;
            S_BS_CHK:   state_next = stat.bs_more ? S_BS_CMP : S_BS_END;
            S_BS_CMP:   state_next = S_BS_CHK;
            S_BS_END:
            begin
                if (stat.op == OP_FIND)
                begin
                    state_next = stat.has_up ? S_FIND_CMP : S_DONE;
                end
                else
                begin
                    state_next = stat.has_up ? S_Q_UP : S_Q_LO_REQ;
                end
            end
            S_FIND_CMP: state_next = S_DONE;
            S_Q_UP:     state_next = stat.has_lo ? S_Q_LO_REQ : S_Q_EVAL;
            S_Q_LO_REQ: state_next = S_Q_LO;
            S_Q_LO:     state_next = S_Q_EVAL;
            S_Q_EVAL:   state_next = S_Q_OFF;
            S_Q_OFF:    state_next = stat.need_div ? S_DIV : S_DONE;
            S_DIV:      state_next = stat.div_last ? S_DONE : S_DIV;
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.raddr_sel = RA_PTR_M1;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_INSERT: cmd.set_full = stat.full;
                    OP_CLEAR:  cmd.clr_count = 1'b1;
                    OP_READ:
                    begin
                        cmd.raddr_sel = RA_SLOT;
                        cmd.set_bad_index = !stat.slot_ok;
                    end
                    default:   cmd.raddr_sel = RA_PTR_M1;
                endcase
            end
            S_INS_CHK:  cmd.raddr_sel = RA_PTR_M1;
            S_INS_CMP:
            begin
                cmd.ram_we = stat.greater;
                cmd.ptr_dec = stat.greater;
            end
            S_INS_PUT:
            begin
                cmd.ram_we = 1'b1;
                cmd.wr_stamp = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_RD_CAP:   cmd.cap_lower = 1'b1;
            S_BS_CHK:   cmd.raddr_sel = RA_MID;
            S_BS_CMP:   cmd.bs_step = 1'b1;
            S_BS_END:
            begin
                cmd.raddr_sel = RA_LO;
                cmd.set_not_found = (stat.op == OP_FIND) && !stat.has_up;
            end
            S_FIND_CMP:
            begin
                cmd.set_pos = stat.equal;
                cmd.set_not_found = !stat.equal;
            end
            S_Q_UP:     cmd.cap_upper = 1'b1;
            S_Q_LO_REQ: cmd.raddr_sel = RA_LO_M1;
            S_Q_LO:     cmd.cap_lower = 1'b1;
            S_Q_EVAL:   cmd.eval = 1'b1;
            S_Q_OFF:    cmd.calc_off = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_DONE:     cmd.out_load = !stat.out_busy;
            default:    cmd.raddr_sel = RA_PTR_M1;
        endcase
    end

endmodule

// ----- design/stl_datapath.sv -----
`timescale 1ns / 1ps
`include "sorted_timestamp_nearest_lookup_defines.svh"

module stl_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  stl_pkg::dp_cmd_t                   cmd,
    output stl_pkg::dp_stat_t                  stat,
    input  logic [stl_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stl_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    import stl_pkg::*;

    logic [OP_W-1:0]        op_reg, op_next;
    logic [STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       lo_reg, lo_next;
    logic [CNT_W-1:0]       hi_reg, hi_next;
    logic [STAMP_W-1:0]     lower_reg, lower_next;
    logic [STAMP_W-1:0]     upper_reg, upper_next;
    logic [STAMP_W-1:0]     closest_reg, closest_next;
    logic [STAMP_W-1:0]     offset_reg, offset_next;
    logic [STAMP_W-1:0]     rem_reg, rem_next;
    logic [STAMP_W-1:0]     den_reg, den_next;
    logic [FRAC_W-1:0]      q_reg, q_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   ok_reg, ok_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   div_reg, div_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   lo_m1;
    logic [CNT_W-1:0]   ptr_m1;
    logic [IDX_W-1:0]   raddr;
    logic [STAMP_W-1:0] rdata;
    logic [STAMP_W-1:0] wdata;
    logic [STAMP_W-1:0] dlo;
    logic [STAMP_W-1:0] dhi;
    logic [STAMP_W-1:0] rem_sh;
    logic               take;
    logic               has_lo;
    logic               has_up;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1 = lo_reg - CNT_W'(1);
    assign ptr_m1 = ptr_reg - CNT_W'(1);
    assign has_lo = (lo_reg != '0);
    assign has_up = (lo_reg < count_reg);
    assign dlo = stamp_reg - lower_reg;
    assign dhi = upper_reg - stamp_reg;
    assign rem_sh = {rem_reg[STAMP_W-2:0], 1'b0};
    assign take = rem_reg[STAMP_W-1] || (rem_sh >= den_reg);
    assign wdata = cmd.wr_stamp ? stamp_reg : rdata;

    always_comb
    begin
        case (cmd.raddr_sel)
            RA_MID:   raddr = mid[IDX_W-1:0];
            RA_SLOT:  raddr = IDX_W'(slot_reg);
            RA_LO:    raddr = lo_reg[IDX_W-1:0];
            RA_LO_M1: raddr = lo_m1[IDX_W-1:0];
            default:  raddr = ptr_m1[IDX_W-1:0];
        endcase
    end

    stl_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (ptr_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        stat.op = op_reg;
        stat.full = (count_reg == CNT_W'(TABLE_DEPTH));
        stat.slot_ok = (CMP_W'(slot_reg) < CMP_W'(count_reg));
        stat.count_zero = (count_reg == '0);
        stat.ptr_zero = (ptr_reg == '0);
        stat.bs_more = (lo_reg < hi_reg);
        stat.greater = (rdata > stamp_reg);
        stat.equal = (rdata == stamp_reg);
        stat.has_lo = has_lo;
        stat.has_up = has_up;
        stat.need_div = div_reg;
        stat.div_last = (div_cnt_reg == DIV_CNT_W'(FRAC_W - 1));
        stat.out_busy = out_valid_reg && !m_tready;
    end

    always_comb
    begin
        op_next = op_reg;
        stamp_next = stamp_reg;
        slot_next = slot_reg;
        count_next = count_reg;
        ptr_next = ptr_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        closest_next = closest_reg;
        offset_next = offset_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        q_next = q_reg;
        status_next = status_reg;
        ok_next = ok_reg;
        pos_next = pos_reg;
        div_next = div_reg;
        div_cnt_next = div_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            op_next = s_tdata[OP_W-1:0];
            stamp_next = s_tdata[OP_W +: STAMP_W];
            slot_next = s_tdata[OP_W + STAMP_W +: SLOT_W];
            ptr_next = count_reg;
            lo_next = '0;
            hi_next = count_reg;
            lower_next = '0;
            upper_next = '0;
            closest_next = '0;
            offset_next = '0;
            q_next = '0;
            status_next = ST_OK;
            ok_next = 1'b0;
            pos_next = '0;
            div_next = 1'b0;
        end
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        if (cmd.set_full)
        begin
            status_next = ST_FULL;
        end
        if (cmd.set_bad_index)
        begin
            status_next = ST_BAD_INDEX;
        end
        if (cmd.set_not_found)
        begin
            status_next = ST_NOT_FOUND;
        end
        if (cmd.ptr_dec)
        begin
            ptr_next = ptr_m1;
        end
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.bs_step)
        begin
            if (rdata < stamp_reg)
            begin
                lo_next = mid + CNT_W'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.cap_lower)
        begin
            lower_next = rdata;
        end
        if (cmd.cap_upper)
        begin
            upper_next = rdata;
        end
        if (cmd.set_pos)
        begin
            pos_next = POS_W'(lo_reg);
        end
        if (cmd.eval)
        begin
            div_cnt_next = '0;
            if (has_up && (upper_reg == stamp_reg))
            begin
                lower_next = stamp_reg;
                ok_next = 1'b1;
                closest_next = stamp_reg;
            end
            else if (!has_lo || !has_up)
            begin
                closest_next = (lower_reg != '0) ? lower_reg : upper_reg;
            end
            else
            begin
                ok_next = 1'b1;
                closest_next = (dlo <= dhi) ? lower_reg : upper_reg;
                rem_next = dlo;
                den_next = upper_reg - lower_reg;
                div_next = 1'b1;
            end
        end
        if (cmd.calc_off)
        begin
            offset_next = (closest_reg == '0) ? '0 : stamp_reg - closest_reg;
        end
        if (cmd.div_step)
        begin
            rem_next = take ? rem_sh - den_reg : rem_sh;
            q_next = {q_reg[FRAC_W-2:0], take};
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next = OUT_TDATA_W'({FILL_W'(count_reg), pos_reg,
                                          offset_reg, closest_reg, q_reg, upper_reg,
                                          lower_reg, ok_reg, status_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        stamp_reg <= stamp_next;
        slot_reg <= slot_next;
        ptr_reg <= ptr_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        lower_reg <= lower_next;
        upper_reg <= upper_next;
        closest_reg <= closest_next;
        offset_reg <= offset_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg <= q_next;
        status_reg <= status_next;
        ok_reg <= ok_next;
        pos_reg <= pos_next;
        div_reg <= div_next;
        div_cnt_reg <= div_cnt_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    `STL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `STL_ASSERT_IMP(a_write_in_range, cmd.ram_we, ptr_reg < CNT_W'(TABLE_DEPTH))
    `STL_ASSERT_IMP(a_div_nonzero, cmd.div_step, den_reg != '0)
    `STL_ASSERT_NXT(a_insert_grows, cmd.cnt_inc, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// ----- design/sorted_timestamp_nearest_lookup.sv -----
`timescale 1ns / 1ps
// Insert: entries greater than the stamp move up one slot, top first, then the stamp is
// written in the freed slot; a full table only reports status full. Find: up to
// ceil(log2(fill + 1)) binary search steps, then an equality check. Query: a binary search,
// then the one-bit-per-cycle divider when the stamp lies between two entries; empty: none.
// Read returns one slot. One item at a time: the next beat is taken once the result is registered.
// Reset clears the fill count and the output beat; table contents stay undefined.

module sorted_timestamp_nearest_lookup (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[2:0], stamp[66:3], slot[72:67], zero pad.
    input  logic [stl_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], interval_ok[2], lower_stamp[66:3], upper_stamp[130:67],
    // fraction[146:131], closest[210:147], offset[274:211], position[280:275],
    // fill[287:281].
    output logic [stl_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import stl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    stl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
